[rtl/sct_pkg.sv]
// Package for the source code tokenizer: token kinds, error codes, scan modes
// and the result-slot record passed from the scanner to the emitter.
// No dependencies.
package sct_pkg;

  localparam int KIND_W = 6;
  localparam int ERR_W = 3;

  localparam logic [KIND_W-1:0] K_COMMENT = 6'd0;
  localparam logic [KIND_W-1:0] K_INT = 6'd1;
  localparam logic [KIND_W-1:0] K_FLOAT = 6'd2;
  localparam logic [KIND_W-1:0] K_STRING = 6'd3;
  localparam logic [KIND_W-1:0] K_SYMBOL = 6'd4;
  localparam logic [KIND_W-1:0] K_KWBASE = 6'd5;
  localparam logic [KIND_W-1:0] K_OPBASE = 6'd15;
  localparam logic [KIND_W-1:0] K_EQ = 6'd27;
  localparam logic [KIND_W-1:0] K_GT = 6'd29;
  localparam logic [KIND_W-1:0] K_LT = 6'd31;

  localparam logic [ERR_W-1:0] E_NONE = 3'd0;
  localparam logic [ERR_W-1:0] E_UNKNOWN = 3'd1;
  localparam logic [ERR_W-1:0] E_DOT = 3'd2;
  localparam logic [ERR_W-1:0] E_DANGLE = 3'd3;
  localparam logic [ERR_W-1:0] E_ESCAPE = 3'd4;
  localparam logic [ERR_W-1:0] E_UNTERM = 3'd5;

  typedef enum logic [9:0] {
    M_IDLE    = 10'b0000000001,
    M_COMMENT = 10'b0000000010,
    M_NUMBER  = 10'b0000000100,
    M_SYMBOL  = 10'b0000001000,
    M_STRING  = 10'b0000010000,
    M_ESCAPE  = 10'b0000100000,
    M_OPEQ    = 10'b0001000000,
    M_OPGT    = 10'b0010000000,
    M_OPLT    = 10'b0100000000,
    M_ERROR   = 10'b1000000000
  } mode_t;

  // one result without position; position travels once per item
  typedef struct packed {
    logic              used;
    logic [KIND_W-1:0] kind;
    logic [7:0]        data;
    logic              data_valid;
    logic              token_end;
    logic [ERR_W-1:0]  error_code;
    logic              at_byte;
  } slot_t;

  function automatic logic [KIND_W-1:0] single_op(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    k = '0;
    case (c)
      8'h7B: k = K_OPBASE + 6'd0;
      8'h7D: k = K_OPBASE + 6'd1;
      8'h5B: k = K_OPBASE + 6'd2;
      8'h5D: k = K_OPBASE + 6'd3;
      8'h28: k = K_OPBASE + 6'd4;
      8'h29: k = K_OPBASE + 6'd5;
      8'h2B: k = K_OPBASE + 6'd6;
      8'h2D: k = K_OPBASE + 6'd7;
      8'h2A: k = K_OPBASE + 6'd8;
      8'h2F: k = K_OPBASE + 6'd9;
      8'h5E: k = K_OPBASE + 6'd10;
      8'h2C: k = K_OPBASE + 6'd11;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_symch(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           c == 8'h5F || c == 8'h21 || c == 8'h3F;
  endfunction

endpackage

[rtl/sct_scan.sv]
// Front end: accepts source bytes, runs the lexer state machine and builds up to
// three result slots per byte with the positions they carry.
// Depends on sct_pkg.
module sct_scan #(
  parameter int POSITION_WIDTH = 16,
  parameter int KEYWORD_CHARS = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                byte_in,
  input  logic                      last_byte,
  output logic                      q_valid,
  input  logic                      q_ready,
  output sct_pkg::slot_t [2:0]      q_slots,
  output logic [POSITION_WIDTH-1:0] q_tok_row,
  output logic [POSITION_WIDTH-1:0] q_tok_col,
  output logic [POSITION_WIDTH-1:0] q_byte_row,
  output logic [POSITION_WIDTH-1:0] q_byte_col
);

  localparam int LW = $clog2(KEYWORD_CHARS + 2);
  localparam logic [POSITION_WIDTH-1:0] PMAX = '1;

  sct_pkg::mode_t mode, mode_next;
  logic seen_dot, seen_dot_next;
  logic [7:0] kwbuf [KEYWORD_CHARS];
  logic [7:0] kwbuf_next [KEYWORD_CHARS];
  logic [LW-1:0] sym_len, sym_len_next;
  logic [POSITION_WIDTH-1:0] row, col, row_next, col_next;
  logic [POSITION_WIDTH-1:0] trow, tcol, trow_next, tcol_next;
  logic [sct_pkg::ERR_W-1:0] err, err_next;
  sct_pkg::slot_t [2:0] sl;
  logic [1:0] n;
  logic accept;

  assign in_ready = !q_valid || q_ready;
  assign accept = in_valid && in_ready;

  function automatic logic [sct_pkg::KIND_W-1:0] sym_kind(
    input logic [7:0] b [KEYWORD_CHARS], input logic [LW-1:0] len);
    logic [sct_pkg::KIND_W-1:0] k;
    logic t;
    k = sct_pkg::K_SYMBOL;
    t = 1'b1;
    for (int i = 5; i < KEYWORD_CHARS; i++) t = t && b[i] == 8'h00;
    if (t) begin
      case ({len, b[0], b[1], b[2], b[3], b[4]} & {{LW{1'b1}}, 40'hFFFFFFFFFF})
        {LW'(3), 40'h616E640000}: k = sct_pkg::K_KWBASE + 6'd0;
        {LW'(3), 40'h6E6F740000}: k = sct_pkg::K_KWBASE + 6'd1;
        {LW'(2), 40'h6F72000000}: k = sct_pkg::K_KWBASE + 6'd2;
        {LW'(4), 40'h66756E6300}: k = sct_pkg::K_KWBASE + 6'd3;
        {LW'(3), 40'h7661720000}: k = sct_pkg::K_KWBASE + 6'd4;
        {LW'(2), 40'h6966000000}: k = sct_pkg::K_KWBASE + 6'd5;
        {LW'(5), 40'h7768696C65}: k = sct_pkg::K_KWBASE + 6'd6;
        {LW'(2), 40'h646F000000}: k = sct_pkg::K_KWBASE + 6'd7;
        {LW'(3), 40'h656E640000}: k = sct_pkg::K_KWBASE + 6'd8;
        {LW'(4), 40'h656C736500}: k = sct_pkg::K_KWBASE + 6'd9;
        default: k = sct_pkg::K_SYMBOL;
      endcase
    end
    return k;
  endfunction

  always_comb begin
    logic used;
    logic [7:0] c, esc;
    logic [sct_pkg::KIND_W-1:0] k;
    logic ws;
    logic fresh;
    used = 1'b0;
    fresh = 1'b0;
    c = byte_in;
    esc = 8'h00;
    k = '0;
    ws = c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    mode_next = mode;
    seen_dot_next = seen_dot;
    kwbuf_next = kwbuf;
    sym_len_next = sym_len;
    trow_next = trow;
    tcol_next = tcol;
    err_next = err;
    sl = '0;
    n = 2'd0;
    row_next = row;
    col_next = col;
    if (mode == sct_pkg::M_ERROR) begin
      if (last_byte) begin
        sl[0] = '{1'b1, sct_pkg::K_COMMENT, 8'h00, 1'b0, 1'b0, err, 1'b0};
        n = 2'd1;
      end
    end else begin
      case (mode)
        sct_pkg::M_COMMENT: begin
          if (c == 8'h0A) begin
            sl[n] = '{1'b1, sct_pkg::K_COMMENT, 8'h00, 1'b0, 1'b1, sct_pkg::E_NONE, 1'b0};
            n = n + 2'd1;
            mode_next = sct_pkg::M_IDLE;
          end else begin
            sl[n] = '{1'b1, sct_pkg::K_COMMENT, c, 1'b1, 1'b0, sct_pkg::E_NONE, 1'b0};
            n = n + 2'd1;
            used = 1'b1;
          end
        end
        sct_pkg::M_NUMBER: begin
          if (sct_pkg::is_digit(c)) begin
            sl[n] = '{1'b1, seen_dot ? sct_pkg::K_FLOAT : sct_pkg::K_INT, c, 1'b1, 1'b0,
                      sct_pkg::E_NONE, 1'b0};
            n = n + 2'd1;
            used = 1'b1;
          end else if (c == 8'h2E) begin
            used = 1'b1;
            if (seen_dot) begin
              sl[n] = '{1'b1, sct_pkg::K_COMMENT, 8'h00, 1'b0, 1'b0, sct_pkg::E_DOT, 1'b0};
              n = n + 2'd1;
              err_next = sct_pkg::E_DOT;
              mode_next = sct_pkg::M_ERROR;
            end else begin
              seen_dot_next = 1'b1;
              sl[n] = '{1'b1, sct_pkg::K_FLOAT, c, 1'b1, 1'b0, sct_pkg::E_NONE, 1'b0};
              n = n + 2'd1;
            end
          end else begin
            sl[n] = '{1'b1, seen_dot ? sct_pkg::K_FLOAT : sct_pkg::K_INT, 8'h00, 1'b0, 1'b1,
                      sct_pkg::E_NONE, 1'b0};
            n = n + 2'd1;
            mode_next = sct_pkg::M_IDLE;
          end
        end
        sct_pkg::M_SYMBOL: begin
          if (sct_pkg::is_symch(c)) begin
            for (int i = 0; i < KEYWORD_CHARS; i++)
              if (sym_len == LW'(i)) kwbuf_next[i] = c;
            if (sym_len <= LW'(KEYWORD_CHARS)) sym_len_next = sym_len + 1'b1;
            sl[n] = '{1'b1, sct_pkg::K_SYMBOL, c, 1'b1, 1'b0, sct_pkg::E_NONE, 1'b0};
            n = n + 2'd1;
            used = 1'b1;
          end else begin
            sl[n] = '{1'b1, (sym_len > LW'(KEYWORD_CHARS)) ? sct_pkg::K_SYMBOL :
                      sym_kind(kwbuf, sym_len), 8'h00, 1'b0, 1'b1, sct_pkg::E_NONE, 1'b0};
            n = n + 2'd1;
            mode_next = sct_pkg::M_IDLE;
          end
        end
        sct_pkg::M_STRING: begin
          used = 1'b1;
          if (c == 8'h22) begin
            sl[n] = '{1'b1, sct_pkg::K_STRING, 8'h00, 1'b0, 1'b1, sct_pkg::E_NONE, 1'b0};
            n = n + 2'd1;
            mode_next = sct_pkg::M_IDLE;
          end else if (c == 8'h5C) begin
            mode_next = sct_pkg::M_ESCAPE;
          end else begin
            sl[n] = '{1'b1, sct_pkg::K_STRING, c, 1'b1, 1'b0, sct_pkg::E_NONE, 1'b0};
            n = n + 2'd1;
          end
        end
        sct_pkg::M_ESCAPE: begin
          used = 1'b1;
          if (c == 8'h22 || c == 8'h5C) esc = c;
          else if (c == 8'h6E) esc = 8'd10;
          else if (c == 8'h74) esc = 8'd9;
          if (esc != 8'h00) begin
            sl[n] = '{1'b1, sct_pkg::K_STRING, esc, 1'b1, 1'b0, sct_pkg::E_NONE, 1'b0};
            n = n + 2'd1;
            mode_next = sct_pkg::M_STRING;
          end else begin
            sl[n] = '{1'b1, sct_pkg::K_COMMENT, 8'h00, 1'b0, 1'b0, sct_pkg::E_ESCAPE, 1'b0};
            n = n + 2'd1;
            err_next = sct_pkg::E_ESCAPE;
            mode_next = sct_pkg::M_ERROR;
          end
        end
        sct_pkg::M_OPEQ, sct_pkg::M_OPGT, sct_pkg::M_OPLT: begin
          k = (mode == sct_pkg::M_OPEQ) ? sct_pkg::K_EQ :
              (mode == sct_pkg::M_OPGT) ? sct_pkg::K_GT : sct_pkg::K_LT;
          if (c == 8'h3D) begin
            sl[0] = '{1'b1, k + 6'd1, c, 1'b1, 1'b0, sct_pkg::E_NONE, 1'b0};
            sl[1] = '{1'b1, k + 6'd1, 8'h00, 1'b0, 1'b1, sct_pkg::E_NONE, 1'b0};
            n = 2'd2;
            used = 1'b1;
          end else begin
            sl[0] = '{1'b1, k, 8'h00, 1'b0, 1'b1, sct_pkg::E_NONE, 1'b0};
            n = 2'd1;
          end
          mode_next = sct_pkg::M_IDLE;
        end
        default: mode_next = sct_pkg::M_IDLE;
      endcase

      // token start from idle
      if (!used && mode_next == sct_pkg::M_IDLE && !ws) begin
        trow_next = row;
        tcol_next = col;
        fresh = 1'b1;
        if (c == 8'h23) begin
          mode_next = sct_pkg::M_COMMENT;
          sl[n] = '{1'b1, sct_pkg::K_COMMENT, c, 1'b1, 1'b0, sct_pkg::E_NONE, 1'b1};
          n = n + 2'd1;
        end else if (sct_pkg::is_digit(c)) begin
          mode_next = sct_pkg::M_NUMBER;
          seen_dot_next = 1'b0;
          sl[n] = '{1'b1, sct_pkg::K_INT, c, 1'b1, 1'b0, sct_pkg::E_NONE, 1'b1};
          n = n + 2'd1;
        end else if (sct_pkg::is_symch(c)) begin
          mode_next = sct_pkg::M_SYMBOL;
          for (int i = 0; i < KEYWORD_CHARS; i++) kwbuf_next[i] = 8'h00;
          kwbuf_next[0] = c;
          sym_len_next = LW'(1);
          sl[n] = '{1'b1, sct_pkg::K_SYMBOL, c, 1'b1, 1'b0, sct_pkg::E_NONE, 1'b1};
          n = n + 2'd1;
        end else if (c == 8'h22) begin
          mode_next = sct_pkg::M_STRING;
        end else if (c == 8'h3D || c == 8'h3E || c == 8'h3C) begin
          mode_next = (c == 8'h3D) ? sct_pkg::M_OPEQ :
                      (c == 8'h3E) ? sct_pkg::M_OPGT : sct_pkg::M_OPLT;
          k = (c == 8'h3D) ? sct_pkg::K_EQ : (c == 8'h3E) ? sct_pkg::K_GT : sct_pkg::K_LT;
          sl[n] = '{1'b1, k, c, 1'b1, 1'b0, sct_pkg::E_NONE, 1'b1};
          n = n + 2'd1;
        end else if (sct_pkg::single_op(c) != '0) begin
          k = sct_pkg::single_op(c);
          sl[n] = '{1'b1, k, c, 1'b1, 1'b0, sct_pkg::E_NONE, 1'b1};
          sl[n+2'd1] = '{1'b1, k, 8'h00, 1'b0, 1'b1, sct_pkg::E_NONE, 1'b1};
          n = n + 2'd2;
        end else begin
          sl[n] = '{1'b1, sct_pkg::K_COMMENT, 8'h00, 1'b0, 1'b0, sct_pkg::E_UNKNOWN, 1'b1};
          n = n + 2'd1;
          err_next = sct_pkg::E_UNKNOWN;
          mode_next = sct_pkg::M_ERROR;
        end
      end

      if (c == 8'h0A) begin
        if (row != PMAX) row_next = row + 1'b1;
        col_next = POSITION_WIDTH'(1);
      end else if (col != PMAX) begin
        col_next = col + 1'b1;
      end

      if (last_byte) begin
        case (mode_next)
          sct_pkg::M_COMMENT: sl[n] = '{1'b1, sct_pkg::K_COMMENT, 8'h00, 1'b0, 1'b1,
                                        sct_pkg::E_NONE, fresh};
          sct_pkg::M_NUMBER: sl[n] = '{1'b1, seen_dot_next ? sct_pkg::K_FLOAT :
                                       sct_pkg::K_INT, 8'h00, 1'b0, 1'b1, sct_pkg::E_NONE, fresh};
          sct_pkg::M_SYMBOL: sl[n] = '{1'b1, (sym_len_next > LW'(KEYWORD_CHARS)) ?
                                       sct_pkg::K_SYMBOL : sym_kind(kwbuf_next, sym_len_next),
                                       8'h00, 1'b0, 1'b1, sct_pkg::E_NONE, fresh};
          sct_pkg::M_OPEQ: sl[n] = '{1'b1, sct_pkg::K_EQ, 8'h00, 1'b0, 1'b1,
                                     sct_pkg::E_NONE, fresh};
          sct_pkg::M_OPGT: sl[n] = '{1'b1, sct_pkg::K_GT, 8'h00, 1'b0, 1'b1,
                                     sct_pkg::E_NONE, fresh};
          sct_pkg::M_OPLT: sl[n] = '{1'b1, sct_pkg::K_LT, 8'h00, 1'b0, 1'b1,
                                     sct_pkg::E_NONE, fresh};
          sct_pkg::M_STRING: sl[n] = '{1'b1, sct_pkg::K_COMMENT, 8'h00, 1'b0, 1'b0,
                                       sct_pkg::E_UNTERM, fresh};
          sct_pkg::M_ESCAPE: sl[n] = '{1'b1, sct_pkg::K_COMMENT, 8'h00, 1'b0, 1'b0,
                                       sct_pkg::E_DANGLE, fresh};
          default: ;
        endcase
      end
    end

    if (last_byte) begin
      mode_next = sct_pkg::M_IDLE;
      seen_dot_next = 1'b0;
      for (int i = 0; i < KEYWORD_CHARS; i++) kwbuf_next[i] = 8'h00;
      sym_len_next = '0;
      row_next = POSITION_WIDTH'(1);
      col_next = POSITION_WIDTH'(1);
      trow_next = POSITION_WIDTH'(1);
      tcol_next = POSITION_WIDTH'(1);
      err_next = sct_pkg::E_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sct_pkg::M_IDLE;
      seen_dot <= 1'b0;
      for (int i = 0; i < KEYWORD_CHARS; i++) kwbuf[i] <= 8'h00;
      sym_len <= '0;
      row <= POSITION_WIDTH'(1);
      col <= POSITION_WIDTH'(1);
      trow <= POSITION_WIDTH'(1);
      tcol <= POSITION_WIDTH'(1);
      err <= sct_pkg::E_NONE;
      q_valid <= 1'b0;
    end else begin
      if (in_ready) q_valid <= accept && (sl[0].used || sl[1].used || sl[2].used);
      if (accept) begin
        mode <= mode_next;
        seen_dot <= seen_dot_next;
        kwbuf <= kwbuf_next;
        sym_len <= sym_len_next;
        row <= row_next;
        col <= col_next;
        trow <= trow_next;
        tcol <= tcol_next;
        err <= err_next;
      end
    end
  end

  // token position for the slot record: start of the open token, or the byte
  always_ff @(posedge clk) begin
    if (accept && in_ready) begin
      q_slots <= sl;
      q_tok_row <= trow;
      q_tok_col <= tcol;
      q_byte_row <= row;
      q_byte_col <= col;
    end
  end

endmodule

[rtl/sct_emit.sv]
// Back end: takes one queued record of up to three result slots and sends them
// out one word per cycle while the receiver is ready, marking the last of the record.
// Depends on sct_pkg.
module sct_emit #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  sct_pkg::slot_t [2:0]      q_slots,
  input  logic [POSITION_WIDTH-1:0] q_tok_row,
  input  logic [POSITION_WIDTH-1:0] q_tok_col,
  input  logic [POSITION_WIDTH-1:0] q_byte_row,
  input  logic [POSITION_WIDTH-1:0] q_byte_col,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sct_pkg::slot_t            out_slot,
  output logic [POSITION_WIDTH-1:0] out_row,
  output logic [POSITION_WIDTH-1:0] out_col,
  output logic                      out_last
);

  logic [1:0] idx;
  sct_pkg::slot_t cur;
  logic last_here;
  logic fire;

  assign cur = q_slots[idx];
  assign last_here = (idx == 2'd2) || !q_slots[(idx == 2'd0) ? 2'd1 : 2'd2].used;
  assign fire = q_valid && (!out_valid || out_ready);
  assign q_ready = fire && last_here;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready || !out_valid) out_valid <= q_valid;
      if (fire) idx <= last_here ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_slot <= cur;
      out_row <= cur.at_byte ? q_byte_row : q_tok_row;
      out_col <= cur.at_byte ? q_byte_col : q_tok_col;
      out_last <= last_here;
    end
  end

endmodule

[rtl/source_code_tokenizer_core.sv]
// Top level of the source code tokenizer: scanner front end, one-record queue,
// emitter back end. Depends on sct_pkg, sct_scan and sct_emit.
//
// Usage: feed one source byte per word on s_axis (tdata = byte_in, tlast =
// last_byte). Each byte yields zero to three result words on m_axis; tuser
// carries run_last, set on the last word a byte caused. Token bytes arrive
// with a provisional kind; the final kind comes on the token-end word.
// Pipeline: two register stages, the scan record register and then the emitter
// output register; each result word passes through both.
// Throughput: one byte per cycle while each byte gives at most one word and
// m_axis is ready; a byte with two or three words holds the input until the
// single output port of the emitter has drained its record.
// Reset: synchronous rst clears all scan state to the start of a new source.
// A stalled receiver fills the record register, then holds s_axis_tready low;
// nothing is lost. After an error only the last byte repeats the error.
module source_code_tokenizer_core #(
  parameter int POSITION_WIDTH = 16,
  parameter int KEYWORD_CHARS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] kind, [13:6] data, [14] data_valid, [15] token_end,
  // [15+PW:16] start_row, [15+2PW:16+PW] start_col, [18+2PW:16+2PW] error_code
  output logic [((19 + 2*POSITION_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic        m_axis_tuser    // [0] run_last
);

  localparam int PW = POSITION_WIDTH;
  localparam int DW = ((19 + 2*PW + 7) / 8) * 8;

  logic q_valid, q_ready;
  sct_pkg::slot_t [2:0] q_slots;
  logic [PW-1:0] q_tok_row, q_tok_col, q_byte_row, q_byte_col;
  sct_pkg::slot_t os;
  logic [PW-1:0] orow, ocol;

  sct_scan #(.POSITION_WIDTH(PW), .KEYWORD_CHARS(KEYWORD_CHARS)) u_scan (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .byte_in(s_axis_tdata), .last_byte(s_axis_tlast),
    .q_valid(q_valid), .q_ready(q_ready), .q_slots(q_slots),
    .q_tok_row(q_tok_row), .q_tok_col(q_tok_col),
    .q_byte_row(q_byte_row), .q_byte_col(q_byte_col)
  );

  sct_emit #(.POSITION_WIDTH(PW)) u_emit (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_slots(q_slots),
    .q_tok_row(q_tok_row), .q_tok_col(q_tok_col),
    .q_byte_row(q_byte_row), .q_byte_col(q_byte_col),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_slot(os), .out_row(orow), .out_col(ocol), .out_last(m_axis_tuser)
  );

  assign m_axis_tdata = DW'({os.error_code, ocol, orow, os.token_end, os.data_valid,
                             os.data, os.kind});

  a_err_nodata: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && os.error_code != sct_pkg::E_NONE |-> !os.data_valid && !os.token_end)
    else $error("error word carries token data");
  a_end_nodata: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && os.token_end |-> !os.data_valid && os.data == 8'h00)
    else $error("token end word carries data");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

endmodule

[tb/tb_source_code_tokenizer_core.sv]
// Self-checking testbench for source_code_tokenizer_core: drives source bytes,
// predicts the token words and compares them. Depends on sct_pkg and the RTL.
module tb_source_code_tokenizer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = 16;
  localparam int TDW = ((19 + 2*PW + 7) / 8) * 8;
  localparam logic [15:0] POS_MAX = 16'hFFFF;

  localparam int S_IDLE = 0, S_COMMENT = 1, S_NUMBER = 2, S_SYMBOL = 3, S_STRING = 4;
  localparam int S_ESCAPE = 5, S_OPEQ = 6, S_OPGT = 7, S_OPLT = 8, S_ERROR = 9;

  typedef struct {
    logic [7:0] b;
    bit         last;
  } src_byte_t;

  typedef struct {
    logic [5:0]  kind;
    logic [7:0]  data;
    logic        dv;
    logic        te;
    logic [15:0] row;
    logic [15:0] col;
    logic [2:0]  err;
    logic        last;
  } token_word_t;

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tready, s_axis_tlast = 0;
  logic [7:0] s_axis_tdata = 0;
  logic m_axis_tvalid, m_axis_tready = 0, m_axis_tuser;
  logic [TDW-1:0] m_axis_tdata;

  source_code_tokenizer_core DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  src_byte_t   pending[$];
  token_word_t token_q[$];
  int idle_pct = 0, stall_pct = 0;
  int mismatches = 0, words_seen = 0, bytes_taken = 0;
  bit word_taken = 0;

  // predictor state
  int mode = S_IDLE;
  bit seen_dot;
  logic [7:0] kbuf[5];
  int symlen;
  logic [15:0] row, col, trow, tcol;
  logic [2:0] errc;
  int nres;

  task automatic clear_scan();
    mode = S_IDLE; seen_dot = 0; symlen = 0;
    foreach (kbuf[i]) kbuf[i] = 0;
    row = 1; col = 1; trow = 1; tcol = 1; errc = sct_pkg::E_NONE;
  endtask

  task automatic put(input logic [5:0] k, input logic [7:0] d, input logic dv,
                     input logic te, input logic [15:0] r, input logic [15:0] c,
                     input logic [2:0] e);
    token_word_t w;
    if (nres >= 3) return;
    w.kind = k; w.data = d; w.dv = dv; w.te = te; w.row = r; w.col = c; w.err = e;
    w.last = 0;
    token_q.push_back(w);
    nres++;
  endtask

  task automatic put_byte(input logic [5:0] k, input logic [7:0] d);
    put(k, d, 1, 0, trow, tcol, sct_pkg::E_NONE);
  endtask

  task automatic put_end(input logic [5:0] k);
    put(k, 0, 0, 1, trow, tcol, sct_pkg::E_NONE);
  endtask

  task automatic flag_error(input logic [2:0] e, input logic [15:0] r, input logic [15:0] c);
    errc = e; trow = r; tcol = c;
    put(sct_pkg::K_COMMENT, 0, 0, 0, r, c, e);
    mode = S_ERROR;
  endtask

  function automatic bit digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit symch(input logic [7:0] c);
    return digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           c == "_" || c == "!" || c == "?";
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] c);
    case (c)
      "{": return sct_pkg::K_OPBASE + 0;  "}": return sct_pkg::K_OPBASE + 1;
      "[": return sct_pkg::K_OPBASE + 2;  "]": return sct_pkg::K_OPBASE + 3;
      "(": return sct_pkg::K_OPBASE + 4;  ")": return sct_pkg::K_OPBASE + 5;
      "+": return sct_pkg::K_OPBASE + 6;  "-": return sct_pkg::K_OPBASE + 7;
      "*": return sct_pkg::K_OPBASE + 8;  "/": return sct_pkg::K_OPBASE + 9;
      "^": return sct_pkg::K_OPBASE + 10; ",": return sct_pkg::K_OPBASE + 11;
      default: return 6'h3F;
    endcase
  endfunction

  function automatic logic [5:0] word_kind();
    logic [39:0] v;
    v = 0;
    if (symlen > 5) return sct_pkg::K_SYMBOL;
    for (int i = 0; i < symlen; i++) v = {v[31:0], kbuf[i]};
    case (v)
      40'("and"): return sct_pkg::K_KWBASE + 0;   40'("not"): return sct_pkg::K_KWBASE + 1;
      40'("or"): return sct_pkg::K_KWBASE + 2;    40'("func"): return sct_pkg::K_KWBASE + 3;
      40'("var"): return sct_pkg::K_KWBASE + 4;   40'("if"): return sct_pkg::K_KWBASE + 5;
      40'("while"): return sct_pkg::K_KWBASE + 6; 40'("do"): return sct_pkg::K_KWBASE + 7;
      40'("end"): return sct_pkg::K_KWBASE + 8;   40'("else"): return sct_pkg::K_KWBASE + 9;
      default: return sct_pkg::K_SYMBOL;
    endcase
  endfunction

  task automatic open_token(input int m, input logic [15:0] r, input logic [15:0] c);
    mode = m; trow = r; tcol = c;
  endtask

  task automatic start_from_idle(input logic [7:0] c, input logic [15:0] r,
                                 input logic [15:0] cl);
    logic [5:0] k;
    k = op_kind(c);
    if (c == " " || (c >= 9 && c <= 13)) return;
    if (c == "#") begin
      open_token(S_COMMENT, r, cl); put_byte(sct_pkg::K_COMMENT, c);
    end else if (digit(c)) begin
      open_token(S_NUMBER, r, cl); seen_dot = 0; put_byte(sct_pkg::K_INT, c);
    end else if (symch(c)) begin
      open_token(S_SYMBOL, r, cl);
      foreach (kbuf[i]) kbuf[i] = 0;
      kbuf[0] = c; symlen = 1; put_byte(sct_pkg::K_SYMBOL, c);
    end else if (c == "\"") begin
      open_token(S_STRING, r, cl);
    end else if (c == "=") begin
      open_token(S_OPEQ, r, cl); put_byte(sct_pkg::K_EQ, c);
    end else if (c == ">") begin
      open_token(S_OPGT, r, cl); put_byte(sct_pkg::K_GT, c);
    end else if (c == "<") begin
      open_token(S_OPLT, r, cl); put_byte(sct_pkg::K_LT, c);
    end else if (k != 6'h3F) begin
      trow = r; tcol = cl; put_byte(k, c); put_end(k);
    end else begin
      flag_error(sct_pkg::E_UNKNOWN, r, cl);
    end
  endtask

  task automatic predict_tokens(input logic [7:0] c, input bit lst);
    int first;
    bit used;
    logic [7:0] esc;
    logic [15:0] r, cl;
    logic [5:0] k;
    token_word_t w;
    first = token_q.size(); nres = 0; used = 0; esc = 0; r = row; cl = col;
    if (mode == S_ERROR) begin
      if (lst) begin
        put(sct_pkg::K_COMMENT, 0, 0, 0, trow, tcol, errc);
        clear_scan();
      end
    end else begin
      case (mode)
        S_COMMENT: begin
          if (c == 8'h0A) begin
            put_end(sct_pkg::K_COMMENT); mode = S_IDLE;
          end else begin
            put_byte(sct_pkg::K_COMMENT, c); used = 1;
          end
        end
        S_NUMBER: begin
          if (digit(c)) begin
            put_byte(seen_dot ? sct_pkg::K_FLOAT : sct_pkg::K_INT, c); used = 1;
          end else if (c == ".") begin
            used = 1;
            if (seen_dot) flag_error(sct_pkg::E_DOT, trow, tcol);
            else begin
              seen_dot = 1; put_byte(sct_pkg::K_FLOAT, c);
            end
          end else begin
            put_end(seen_dot ? sct_pkg::K_FLOAT : sct_pkg::K_INT); mode = S_IDLE;
          end
        end
        S_SYMBOL: begin
          if (symch(c)) begin
            if (symlen < 5) kbuf[symlen] = c;
            if (symlen <= 5) symlen++;
            put_byte(sct_pkg::K_SYMBOL, c); used = 1;
          end else begin
            put_end(word_kind()); mode = S_IDLE;
          end
        end
        S_STRING: begin
          used = 1;
          if (c == "\"") begin
            put_end(sct_pkg::K_STRING); mode = S_IDLE;
          end else if (c == "\\") mode = S_ESCAPE;
          else put_byte(sct_pkg::K_STRING, c);
        end
        S_ESCAPE: begin
          used = 1;
          if (c == "\"" || c == "\\") esc = c;
          else if (c == "n") esc = 8'h0A;
          else if (c == "t") esc = 8'h09;
          if (esc != 0) begin
            put_byte(sct_pkg::K_STRING, esc); mode = S_STRING;
          end else flag_error(sct_pkg::E_ESCAPE, trow, tcol);
        end
        S_OPEQ, S_OPGT, S_OPLT: begin
          k = mode == S_OPEQ ? sct_pkg::K_EQ : mode == S_OPGT ? sct_pkg::K_GT : sct_pkg::K_LT;
          if (c == "=") begin
            put_byte(k + 1, c); put_end(k + 1); used = 1;
          end else put_end(k);
          mode = S_IDLE;
        end
        default: mode = S_IDLE;
      endcase
      if (!used && mode == S_IDLE) start_from_idle(c, r, cl);
      if (c == 8'h0A) begin
        if (row < POS_MAX) row++;
        col = 1;
      end else if (col < POS_MAX) col++;
      if (lst) begin
        case (mode)
          S_COMMENT: put_end(sct_pkg::K_COMMENT);
          S_NUMBER: put_end(seen_dot ? sct_pkg::K_FLOAT : sct_pkg::K_INT);
          S_SYMBOL: put_end(word_kind());
          S_OPEQ: put_end(sct_pkg::K_EQ);
          S_OPGT: put_end(sct_pkg::K_GT);
          S_OPLT: put_end(sct_pkg::K_LT);
          S_STRING: flag_error(sct_pkg::E_UNTERM, trow, tcol);
          S_ESCAPE: flag_error(sct_pkg::E_DANGLE, trow, tcol);
          default: ;
        endcase
        clear_scan();
      end
    end
    if (token_q.size() > first) begin
      w = token_q.pop_back(); w.last = 1; token_q.push_back(w);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      predict_tokens(s_axis_tdata, s_axis_tlast);
      bytes_taken++;
      word_taken = 1;
    end
  end

  always @(negedge clk) begin
    src_byte_t it;
    m_axis_tready <= !rst && ($urandom_range(0, 99) >= stall_pct);
    if (rst) s_axis_tvalid <= 0;
    else if (!s_axis_tvalid || word_taken) begin
      word_taken = 0;
      if (pending.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        it = pending.pop_front();
        s_axis_tdata <= it.b; s_axis_tlast <= it.last; s_axis_tvalid <= 1;
      end else s_axis_tvalid <= 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    token_word_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (token_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        w = token_q.pop_front();
        if (m_axis_tdata[5:0] !== w.kind || m_axis_tdata[13:6] !== w.data ||
            m_axis_tdata[14] !== w.dv || m_axis_tdata[15] !== w.te ||
            m_axis_tdata[31:16] !== w.row || m_axis_tdata[47:32] !== w.col ||
            m_axis_tdata[50:48] !== w.err || m_axis_tdata[TDW-1:51] !== '0 ||
            m_axis_tuser !== w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind %0d data %h dv %b te %b pos %0d:%0d err %0d last %b",
                     w.kind, w.data, w.dv, w.te, w.row, w.col, w.err, w.last,
                     "\n          got kind %0d data %h dv %b te %b pos %0d:%0d err %0d last %b",
                     m_axis_tdata[5:0], m_axis_tdata[13:6], m_axis_tdata[14],
                     m_axis_tdata[15], m_axis_tdata[31:16], m_axis_tdata[47:32],
                     m_axis_tdata[50:48], m_axis_tuser);
        end
      end
    end
  end

  task automatic add_text(input string s, input bit lst);
    src_byte_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.b = s[i]; it.last = lst && (i == s.len() - 1);
      pending.push_back(it);
    end
  endtask

  task automatic add_code(input logic [7:0] b, input bit lst);
    src_byte_t it;
    it.b = b; it.last = lst;
    pending.push_back(it);
  endtask

  function automatic string rand_chars(input string set, input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(set[$urandom_range(0, set.len() - 1)])};
    return s;
  endfunction

  // one random source: mostly well-formed tokens, some noise and broken ones
  task automatic add_source(output int n);
    string kw[10] = '{"and", "not", "or", "func", "var", "if", "while", "do", "end", "else"};
    string ops[4] = '{"==", ">=", "<=", "="};
    string symset, digs, s, t;
    string esc[5] = '{"\\n", "\\t", "\\\\", "\\\"", "\\q"};
    int toks;
    symset = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_!?";
    digs = "0123456789";
    s = "";
    toks = $urandom_range(1, 6);
    for (int i = 0; i < toks; i++) begin
      case ($urandom_range(0, 11))
        0, 1: t = kw[$urandom_range(0, 9)];
        2: t = {rand_chars(symset.substr(0, 51), 1), rand_chars(symset, $urandom_range(0, 7))};
        3: t = rand_chars(digs, $urandom_range(1, 4));
        4: t = {rand_chars(digs, $urandom_range(1, 3)), ".",
                rand_chars(digs, $urandom_range(0, 3)),
                ($urandom_range(0, 7) == 0) ? ".1" : ""};
        5: begin
          t = "\"";
          for (int j = $urandom_range(0, 4); j > 0; j--)
            t = {t, ($urandom_range(0, 2) == 0) ? esc[$urandom_range(0, 4)]
                                                : rand_chars("ab #\n=x", 1)};
          if ($urandom_range(0, 5) != 0) t = {t, "\""};
        end
        6: t = {"#", rand_chars("ab c=\"", $urandom_range(0, 4)), "\n"};
        7: t = rand_chars("{}[]()+-*/^,", $urandom_range(1, 3));
        8: t = ops[$urandom_range(0, 3)];
        9: t = rand_chars(" \t\n\r", $urandom_range(1, 2));
        10: t = string'(8'($urandom_range(0, 255)));
        default: t = rand_chars("<>=.$", 1);
      endcase
      if (t.len() == 0) t = " ";
      s = {s, t};
      if ($urandom_range(0, 2) != 0) s = {s, ($urandom_range(0, 3) == 0) ? "\n" : " "};
    end
    for (int i = 0; i < s.len() - 1; i++) add_code(s[i], 0);
    add_code(s[s.len() - 1], 1);
    n = s.len();
  endtask

  task automatic wait_drained();
    while (pending.size() > 0 || s_axis_tvalid) @(posedge clk);
  endtask

  initial begin
    int cnt, n;
    clear_scan();
    repeat (12) @(posedge clk);
    @(negedge clk) rst = 0;

    // directed: escapes, sticky error repeat, high byte, extra dot, open string
    add_text("#c\n\"\\t\\q", 1);
    add_code(8'hFF, 1);
    add_text("1.2.", 1);
    add_text("\"ab", 1);
    add_text("\"\\", 1);
    add_text("a<", 1);
    add_code(8'h80, 0);
    add_text("x", 1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 82 : 20) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 82 : 20) : 0;
      cnt = 0;
      while (cnt < 40) begin
        add_source(n);
        cnt += n;
      end
      wait_drained();
    end
    while (token_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d source bytes and %0d token words over four idle/stall phases",
             bytes_taken, words_seen);
    if (mismatches == 0 && token_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d words still expected", token_q.size());
    $display("*** FAILED ***");
    $finish;
  end
endmodule
